// ===== rtl/fsdm_pkg.sv =====
package fsdm_pkg;

    localparam int DataW  = 64;
    localparam int StepsN = DataW;

    localparam logic [DataW-1:0] SignBit = {1'b1, {(DataW-1){1'b0}}};
    localparam logic [DataW-1:0] AllOnes = {DataW{1'b1}};

    // sign and special-case info that rides along with each request
    typedef struct packed {
        logic a_neg;
        logic b_neg;
        logic div_zero;
        logic ovf;
    } fsdm_side_t;

    // working set of one request inside the divider pipeline
    typedef struct packed {
        logic [DataW-1:0] rem;
        logic [DataW-1:0] acc;
        logic [DataW-1:0] dvs;
        fsdm_side_t       side;
    } fsdm_work_t;

endpackage

// ===== rtl/fsdm_pre.sv =====
module fsdm_pre (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ce,
    input  logic                          in_valid,
    input  logic [fsdm_pkg::DataW-1:0]    dividend,
    input  logic [fsdm_pkg::DataW-1:0]    divisor,
    output logic                          out_valid,
    output fsdm_pkg::fsdm_work_t          out_work
);
    import fsdm_pkg::*;

    logic       valid_reg;
    fsdm_work_t work_reg;
    fsdm_work_t work_next;

    // magnitudes and special cases
    always_comb
    begin
        work_next.side.a_neg    = dividend[DataW-1];
        work_next.side.b_neg    = divisor[DataW-1];
        work_next.side.div_zero = (divisor == '0);
        work_next.side.ovf      = (divisor != '0) && (dividend == SignBit)
                                  && (divisor == AllOnes);
        work_next.rem = '0;
        work_next.acc = dividend[DataW-1] ? (~dividend + 1'b1) : dividend;
        work_next.dvs = divisor[DataW-1] ? (~divisor + 1'b1) : divisor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

// ===== rtl/fsdm_step.sv =====
module fsdm_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 ce,
    input  logic                 in_valid,
    input  fsdm_pkg::fsdm_work_t in_work,
    output logic                 out_valid,
    output fsdm_pkg::fsdm_work_t out_work
);
    import fsdm_pkg::*;

    logic       valid_reg;
    fsdm_work_t work_reg;
    fsdm_work_t work_next;
    logic [DataW+1:0] trial;
    logic             borrow;

    // one restoring radix-2 step: shift in the next dividend bit, try a subtract
    always_comb
    begin
        trial  = {1'b0, in_work.rem, in_work.acc[DataW-1]} - {2'b00, in_work.dvs};
        borrow = trial[DataW+1];
        work_next      = in_work;
        work_next.rem  = borrow ? {in_work.rem[DataW-2:0], in_work.acc[DataW-1]}
                                : trial[DataW-1:0];
        work_next.acc  = {in_work.acc[DataW-2:0], ~borrow};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

// ===== rtl/fsdm_post.sv =====
module fsdm_post (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ce,
    input  logic                          in_valid,
    input  fsdm_pkg::fsdm_work_t          in_work,
    output logic                          out_valid,
    output logic [fsdm_pkg::DataW-1:0]    quotient,
    output logic [fsdm_pkg::DataW-1:0]    remainder,
    output logic                          divide_by_zero,
    output logic                          overflow
);
    import fsdm_pkg::*;

    logic             valid_reg;
    logic [DataW-1:0] quo_reg;
    logic [DataW-1:0] rem_reg;
    logic             dz_reg;
    logic             ov_reg;
    logic [DataW-1:0] quo_next;
    logic [DataW-1:0] rem_next;
    logic [DataW-1:0] opnd_x;
    logic [DataW-1:0] opnd_y;
    logic             diff_sign;
    logic             fix;

    always_comb
    begin
        diff_sign = in_work.side.a_neg ^ in_work.side.b_neg;
        fix       = diff_sign && (in_work.rem != '0);
        // floored correction: -uq - 1 is ~uq
        if (fix)
        begin
            quo_next = ~in_work.acc;
        end
        else if (diff_sign)
        begin
            quo_next = ~in_work.acc + 1'b1;
        end
        else
        begin
            quo_next = in_work.acc;
        end
        // remainder as one subtract with picked operands
        if (fix)
        begin
            opnd_x = in_work.side.a_neg ? in_work.dvs : in_work.rem;
            opnd_y = in_work.side.a_neg ? in_work.rem : in_work.dvs;
        end
        else
        begin
            opnd_x = in_work.side.a_neg ? '0 : in_work.rem;
            opnd_y = in_work.side.a_neg ? in_work.rem : '0;
        end
        rem_next = opnd_x - opnd_y;
        if (in_work.side.div_zero)
        begin
            quo_next = '0;
            rem_next = '0;
        end
        else if (in_work.side.ovf)
        begin
            quo_next = SignBit;
            rem_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            dz_reg  <= in_work.side.div_zero;
            ov_reg  <= in_work.side.ovf;
        end
    end

    assign out_valid      = valid_reg;
    assign quotient       = quo_reg;
    assign remainder      = rem_reg;
    assign divide_by_zero = dz_reg;
    assign overflow       = ov_reg;

endmodule

// ===== rtl/floored_signed_divmod_top.sv =====
// floored signed 64-bit divide with remainder
//
// input stream (s_axis): one request per beat, dividend and divisor packed in
// tdata. output stream (m_axis): one response per request, in request order,
// with floored quotient and remainder in tdata and two flags in tuser.
//
// requests pass through 66 register stages: one stage that takes magnitudes
// and flags special cases, 64 restoring radix-2 stages (one quotient bit
// each, a 66-bit subtract per stage), one stage that fixes signs and applies
// floored rounding.
// throughput is one request per cycle unless m_axis_tready stalls the pipe.
//
// divide by zero gives quotient 0, remainder 0 and divide_by_zero set; the
// most negative dividend over -1 gives the most negative quotient, remainder
// 0 and overflow set.
//
// reset clears all valid bits, so the pipe comes up empty. when the receiver
// holds m_axis_tready low with a response waiting, the whole pipe freezes and
// s_axis_tready drops in the same cycle; nothing is dropped or repeated.
module floored_signed_divmod_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // [63:0] dividend, [127:64] divisor
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // [63:0] quotient, [127:64] remainder
    output logic [1:0]   m_axis_tuser    // [0] divide_by_zero, [1] overflow
);
    import fsdm_pkg::*;

    logic                 ce;
    logic [StepsN:0]      stage_valid;
    fsdm_work_t           stage_work [StepsN+1];
    logic [DataW-1:0]     quotient;
    logic [DataW-1:0]     remainder;
    logic                 divide_by_zero;
    logic                 overflow;

    // global advance: move whenever the output slot is empty or being taken
    assign ce            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;

    // magnitudes and special-case detection
    fsdm_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_axis_tvalid),
        .dividend  (s_axis_tdata[DataW-1:0]),
        .divisor   (s_axis_tdata[2*DataW-1:DataW]),
        .out_valid (stage_valid[0]),
        .out_work  (stage_work[0])
    );

    // one quotient bit per stage, msb first
    for (genvar gi = 0; gi < StepsN; gi++)
    begin : g_step
        fsdm_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .ce        (ce),
            .in_valid  (stage_valid[gi]),
            .in_work   (stage_work[gi]),
            .out_valid (stage_valid[gi+1]),
            .out_work  (stage_work[gi+1])
        );
    end

    // sign fix-up, floored rounding and output register
    fsdm_post u_post (
        .clk            (clk),
        .rst_n          (rst_n),
        .ce             (ce),
        .in_valid       (stage_valid[StepsN]),
        .in_work        (stage_work[StepsN]),
        .out_valid      (m_axis_tvalid),
        .quotient       (quotient),
        .remainder      (remainder),
        .divide_by_zero (divide_by_zero),
        .overflow       (overflow)
    );

    assign m_axis_tdata = {remainder, quotient};
    assign m_axis_tuser = {overflow, divide_by_zero};

endmodule
